// File: rtl/dhcp_option_tag_scanner_assert.svh
// ----------------------------------------------------------------------------
// DHCP option tag scanner assertion macros
// Shorthand for the concurrent checks of the scanner's checker module.
// ----------------------------------------------------------------------------
`ifndef DHCP_OPTION_TAG_SCANNER_ASSERT_SVH
`define DHCP_OPTION_TAG_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner check failed");

// The consequent must hold in the cycle after the antecedent.
`define DOTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner check failed");

`endif

// File: rtl/dots_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option tag scanner package
// Word types, field widths and option tag codes shared by the scanner files.
// ----------------------------------------------------------------------------
package dots_pkg;

   localparam int BYTE_W     = 8;
   localparam int POS_W      = 11;
   localparam int OFFSET_W   = 10;
   localparam int SLOT_W     = 3;
   localparam int WANTED_W   = 56;
   localparam int WANTED_SLOTS = WANTED_W / BYTE_W;

   localparam logic [BYTE_W-1:0] TAG_PAD = 8'h00;
   localparam logic [BYTE_W-1:0] TAG_END = 8'hFF;
   localparam logic [POS_W-1:0]  TLV_HEADER_BYTES = 11'd2;

   localparam logic [WANTED_W-1:0] WANTED_RESET = 56'd1762775746819085;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register index, taken from the upper address bit (8-byte register stride).
   localparam logic CSR_IDX_WANTED_TAGS = 1'b0;

   typedef struct packed {
      logic [BYTE_W-1:0] option_byte;
      logic              final_byte;
   } req_word_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   tag_slot;
      logic                tag_present;
      logic [OFFSET_W-1:0] option_offset;
      logic                last_of_run;
   } rsp_word_type;

endpackage

// File: rtl/dhcp_option_tag_scanner.sv
// ----------------------------------------------------------------------------
// DHCP option tag scanner
// Walks a DHCPv4 option chain byte by byte and reports where wanted tags start.
// ----------------------------------------------------------------------------
// While req_stall is low, the scanner takes one options byte per cycle on
// the req_ channel, with final_byte set on the last byte of the buffer. A
// byte lands in an input register, and the chain logic behind it follows the
// tag/length/value walk: a pad tag moves the next option start on by one
// byte, the end tag stops the scan, and any other tag moves it on by its
// length plus two. For each wanted tag slot the offset of the first option
// start carrying that tag is kept. When the final byte has been handled, all
// slot results move into a result bank and the chain state clears, so the
// next buffer can follow in the very next cycle. The bank sends one word per
// slot, slot zero first, with last_of_run set on the last slot. Bytes of a
// new buffer are taken at one per cycle while the bank sends; only that
// buffer's final byte waits in the input register until the bank has sent
// its last word. The bank can take the next buffer's results only in the
// cycle after its last word has left. The final byte passes through the input
// register and the result bank before the first result word is registered at
// the output. Bytes at offsets of MAX_OPTION_BYTES and beyond, and bytes
// after the end tag, are ignored.
// The wanted tags sit in one 56-bit register at byte address 0, slot k in bits
// 8k+7 down to 8k; write it only while the scanner is idle.
// ----------------------------------------------------------------------------
module dhcp_option_tag_scanner #(
   parameter int NUM_TAG_SLOTS    = 7,
   parameter int MAX_OPTION_BYTES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dots_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dots_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dots_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dots_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dots_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [dots_pkg::WANTED_W-1:0]  wanted_tags;
   logic                           bank_busy;
   logic                           bank_load;
   logic [NUM_TAG_SLOTS-1:0]       bank_found;
   logic [dots_pkg::OFFSET_W-1:0]  bank_offset [NUM_TAG_SLOTS];

   // Wanted-tag register behind the APB-style port.
   dots_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .wanted_tags (wanted_tags)
   );

   // Input register and the chain walk; hands a finished buffer to the bank.
   dots_scan #(
      .NUM_TAG_SLOTS    (NUM_TAG_SLOTS),
      .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .wanted_tags (wanted_tags),
      .bank_busy   (bank_busy),
      .bank_load   (bank_load),
      .bank_found  (bank_found),
      .bank_offset (bank_offset)
   );

   // Result bank and output register, one slot word per cycle while rsp_stall is low.
   dots_emit #(
      .NUM_TAG_SLOTS (NUM_TAG_SLOTS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .bank_load   (bank_load),
      .bank_found  (bank_found),
      .bank_offset (bank_offset),
      .bank_busy   (bank_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

// File: rtl/dots_csr.sv
// ----------------------------------------------------------------------------
// DHCP option tag scanner register port
// APB-style access to the packed wanted-tag register.
// ----------------------------------------------------------------------------
module dots_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dots_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dots_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dots_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [dots_pkg::WANTED_W-1:0]     wanted_tags
);

   logic [dots_pkg::WANTED_W-1:0] wanted_ff;
   logic [dots_pkg::WANTED_W-1:0] wanted_in;
   logic                          hit_wanted;

   assign csr_pready = 1'b1;
   assign hit_wanted = (csr_paddr[dots_pkg::CSR_ADDR_W-1] == dots_pkg::CSR_IDX_WANTED_TAGS);

   always_comb begin
      wanted_in = wanted_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_wanted) begin
         wanted_in = csr_pwdata[dots_pkg::WANTED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= dots_pkg::WANTED_RESET;
      end else begin
         wanted_ff <= wanted_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit_wanted) begin
         csr_prdata = dots_pkg::CSR_DATA_W'(wanted_ff);
      end
   end

   assign wanted_tags = wanted_ff;

endmodule

// File: rtl/dots_scan.sv
// ----------------------------------------------------------------------------
// DHCP option tag scanner chain walker
// Input register and the option chain state, one byte handled per cycle unless a final byte waits for the bank.
// ----------------------------------------------------------------------------
module dots_scan #(
   parameter int NUM_TAG_SLOTS    = 7,
   parameter int MAX_OPTION_BYTES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dots_pkg::req_word_type            req_word,
   input  logic [dots_pkg::WANTED_W-1:0]     wanted_tags,
   input  logic                              bank_busy,
   output logic                              bank_load,
   output logic [NUM_TAG_SLOTS-1:0]          bank_found,
   output logic [dots_pkg::OFFSET_W-1:0]     bank_offset [NUM_TAG_SLOTS]
);

   localparam logic [dots_pkg::POS_W-1:0] POS_LIMIT = dots_pkg::POS_W'(MAX_OPTION_BYTES);

   logic                           in_valid_ff;
   logic                           in_valid_in;
   dots_pkg::req_word_type         in_word_ff;
   logic                           advance;

   logic [dots_pkg::POS_W-1:0]     pos_ff, pos_in, pos_scan;
   logic [dots_pkg::POS_W-1:0]     next_ff, next_in, next_scan;
   logic                           expect_ff, expect_in, expect_scan;
   logic                           ended_ff, ended_in, ended_scan;
   logic [NUM_TAG_SLOTS-1:0]       found_ff, found_in;
   logic [dots_pkg::OFFSET_W-1:0]  offset_ff [NUM_TAG_SLOTS];
   logic [dots_pkg::OFFSET_W-1:0]  offset_in [NUM_TAG_SLOTS];
   logic [dots_pkg::BYTE_W-1:0]    slot_tag  [NUM_TAG_SLOTS];
   logic [dots_pkg::BYTE_W-1:0]    cur_byte;

   // Slots beyond the packed register look for the pad tag.
   for (genvar k = 0; k < NUM_TAG_SLOTS; k++) begin : g_tag
      if (k < dots_pkg::WANTED_SLOTS) begin : g_reg
         assign slot_tag[k] = wanted_tags[k*dots_pkg::BYTE_W +: dots_pkg::BYTE_W];
      end else begin : g_pad
         assign slot_tag[k] = dots_pkg::TAG_PAD;
      end
   end

   // A final byte waits in the input register until the result bank is free.
   assign advance   = in_valid_ff && !(in_word_ff.final_byte && bank_busy);
   assign req_stall = in_valid_ff && !advance;
   assign cur_byte  = in_word_ff.option_byte;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   always_comb begin
      pos_scan    = pos_ff;
      next_scan   = next_ff;
      expect_scan = expect_ff;
      ended_scan  = ended_ff;
      found_in    = found_ff;
      offset_in   = offset_ff;
      if (advance && (pos_ff < POS_LIMIT)) begin
         pos_scan = pos_ff + 1'b1;
         if (!ended_ff) begin
            if (expect_ff) begin
               // The option's tag sat one byte back, so the header adds one here.
               next_scan   = pos_ff + dots_pkg::POS_W'(cur_byte)
                             + (dots_pkg::TLV_HEADER_BYTES - 1'b1);
               expect_scan = 1'b0;
            end else if (pos_ff == next_ff) begin
               if (cur_byte == dots_pkg::TAG_END) begin
                  ended_scan = 1'b1;
               end else begin
                  for (int k = 0; k < NUM_TAG_SLOTS; k++) begin
                     if (!found_ff[k] && (slot_tag[k] == cur_byte)) begin
                        found_in[k]  = 1'b1;
                        offset_in[k] = pos_ff[dots_pkg::OFFSET_W-1:0];
                     end
                  end
                  if (cur_byte == dots_pkg::TAG_PAD) begin
                     next_scan = pos_ff + 1'b1;
                  end else begin
                     expect_scan = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign bank_load   = advance && in_word_ff.final_byte;
   assign bank_found  = found_in;
   assign bank_offset = offset_in;

   always_comb begin
      pos_in    = pos_scan;
      next_in   = next_scan;
      expect_in = expect_scan;
      ended_in  = ended_scan;
      if (bank_load) begin
         pos_in    = '0;
         next_in   = '0;
         expect_in = 1'b0;
         ended_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         next_ff   <= '0;
         expect_ff <= 1'b0;
         ended_ff  <= 1'b0;
         found_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         next_ff   <= next_in;
         expect_ff <= expect_in;
         ended_ff  <= ended_in;
         found_ff  <= bank_load ? '0 : found_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

endmodule

// File: rtl/dots_emit.sv
// ----------------------------------------------------------------------------
// DHCP option tag scanner result emitter
// Holds one buffer's slot results and sends them out one word per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module dots_emit #(
   parameter int NUM_TAG_SLOTS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              bank_load,
   input  logic [NUM_TAG_SLOTS-1:0]          bank_found,
   input  logic [dots_pkg::OFFSET_W-1:0]     bank_offset [NUM_TAG_SLOTS],
   output logic                              bank_busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dots_pkg::rsp_word_type            rsp_word
);

   localparam int IDX_W = (NUM_TAG_SLOTS > 1) ? $clog2(NUM_TAG_SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TAG_SLOTS - 1);

   logic                           bank_valid_ff, bank_valid_in;
   logic [NUM_TAG_SLOTS-1:0]       found_ff;
   logic [dots_pkg::OFFSET_W-1:0]  offset_ff [NUM_TAG_SLOTS];
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   dots_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                           move;
   logic                           is_last;

   assign move    = bank_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign is_last = (idx_ff == IDX_LAST);

   always_comb begin
      bank_valid_in = bank_valid_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      if (move) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.tag_slot      = dots_pkg::SLOT_W'(idx_ff);
         rsp_word_in.tag_present   = found_ff[idx_ff];
         rsp_word_in.option_offset = found_ff[idx_ff] ? offset_ff[idx_ff] : '0;
         rsp_word_in.last_of_run   = is_last;
         if (is_last) begin
            bank_valid_in = 1'b0;
            idx_in        = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (bank_load) begin
         bank_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bank_valid_ff <= bank_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (bank_load) begin
         found_ff  <= bank_found;
         offset_ff <= bank_offset;
      end
   end

   assign bank_busy = bank_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/dots_checker.sv
// ----------------------------------------------------------------------------
// DHCP option tag scanner port checker
// Watches the result channel for slot order and word consistency.
// ----------------------------------------------------------------------------
`include "dhcp_option_tag_scanner_assert.svh"

module dots_checker #(
   parameter int NUM_TAG_SLOTS = 7
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input dots_pkg::rsp_word_type rsp_word
);

   localparam logic [dots_pkg::SLOT_W-1:0] SLOT_LAST = dots_pkg::SLOT_W'(NUM_TAG_SLOTS - 1);

   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Slots of one buffer leave back to back, in order.
   `DOTS_ASSERT_NEXT(a_slot_order, clock, reset, rsp_take && !rsp_word.last_of_run, rsp_valid && (rsp_word.tag_slot == dots_pkg::SLOT_W'($past(rsp_word.tag_slot) + 1'b1)))

   // The run closes exactly on the highest slot.
   `DOTS_ASSERT_SAME(a_last_slot, clock, reset, rsp_valid, rsp_word.last_of_run == (rsp_word.tag_slot == SLOT_LAST))

   // An absent tag reports offset zero.
   `DOTS_ASSERT_SAME(a_absent_zero, clock, reset, rsp_valid && !rsp_word.tag_present, rsp_word.option_offset == '0)

   // A stalled result word holds.
   `DOTS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind dhcp_option_tag_scanner dots_checker #(
   .NUM_TAG_SLOTS (NUM_TAG_SLOTS)
) u_dots_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
